/* sv/touch_poll_ghost_filter_defines.svh */
// Assertion macros for the touch poll ghost filter.
`ifndef TOUCH_POLL_GHOST_FILTER_DEFINES_SVH
`define TOUCH_POLL_GHOST_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define TPGF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("touch poll ghost filter: same-cycle check failed");
`define TPGF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("touch poll ghost filter: next-cycle check failed");
`else
`define TPGF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TPGF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/tpgf_pkg.sv */
// Shared types and constants of the touch poll ghost filter.
package tpgf_pkg;

  localparam int unsigned InW      = 80;
  localparam int unsigned OutW     = 40;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned UpdW     = 16;
  localparam int unsigned ErrW     = 6;
  localparam int unsigned RemCntW  = $clog2(ErrW + 1);

  localparam logic [ErrW-1:0] ErrMax        = '1;
  localparam logic [UpdW-1:0] UpdMax        = '1;
  localparam logic [7:0]      DisableFactor = 8'd4;
  localparam int unsigned     ReadyBit      = 7;
  localparam logic [3:0]      CountMask     = 4'hF;

  localparam logic [1:0] RecNone    = 2'd0;
  localparam logic [1:0] RecDisplay = 2'd1;
  localparam logic [1:0] RecDisable = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WORKAROUND    = 3'd0,
    CFG_IDLE_LEVEL    = 3'd1,
    CFG_POLL_INTERVAL = 3'd2,
    CFG_HOLDOFF       = 3'd3,
    CFG_GHOST_SHORT   = 3'd4,
    CFG_GHOST_LONG    = 3'd5,
    CFG_GHOST_UPDATES = 3'd6,
    CFG_ERRORS_PER    = 3'd7
  } cfg_idx_e;

  // Input request, lowest field in the lowest bits.
  typedef struct packed {
    logic [3:0]       pad;
    logic             recovery_done;
    logic [15:0]      point_y;
    logic [15:0]      point_x;
    logic             points_ok;
    logic [7:0]       status_byte;
    logic             status_ok;
    logic             line_level;
    logic [TimeW-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  recovery_request;
    logic        bus_restart;
    logic        clear_status;
    logic        invalidate;
    logic        point_valid;
    logic [15:0] out_y;
    logic [15:0] out_x;
    logic        point_count;
    logic        polled;
  } out_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic div_start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_err;
    logic rem_done;
  } sts_t;

endpackage

/* sv/touch_poll_ghost_filter.sv */
// Top level of the touch poll ghost filter: handshake ports, controller and datapath.
//
// Usage: each request on the s_axis channel is one touch controller poll; the
// block answers every request with exactly one result on the m_axis channel,
// in order. Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i
// while no request is in flight.
// Timing: a request is taken in ST_IDLE, its time differences are formed in
// ST_CALC, and the poll is decided in ST_CHECK. Without a read error the
// result is registered in ST_COMMIT. A read error adds the ST_DIV state for
// the bit-serial remainder of the error count, one quotient bit per cycle.
// s_axis_tready is high only while the controller is idle; the finished
// result sits in the output register, so a new request is taken while it waits.
// If the receiver stalls, the next result waits in the datapath until the
// output register is free, and no further request is taken meanwhile.
// Reset returns all registers to their defaults and clears the poll state.
`include "touch_poll_ghost_filter_defines.svh"

module touch_poll_ghost_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tpgf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tpgf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // now_ms[31:0], line_level, status_ok, status_byte[7:0], points_ok,
  // point_x[15:0], point_y[15:0], recovery_done, zero fill [79:76]
  input  logic [tpgf_pkg::InW-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // polled, point_count, out_x[15:0], out_y[15:0], point_valid, invalidate,
  // clear_status, bus_restart, recovery_request[1:0]
  output logic [tpgf_pkg::OutW-1:0]     m_axis_tdata
);

  tpgf_pkg::cmd_t cmd;
  tpgf_pkg::sts_t sts;
  tpgf_pkg::out_t res_view;
  logic           rec_ok;

  tpgf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tpgf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata)
  );

  assign res_view = tpgf_pkg::out_t'(m_axis_tdata);
  assign rec_ok   = (res_view.recovery_request == tpgf_pkg::RecNone)
                    || (res_view.recovery_request == tpgf_pkg::RecDisplay)
                    || (res_view.recovery_request == tpgf_pkg::RecDisable);

  `TPGF_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `TPGF_ASSERT_IMP(a_commit_slot_free, clk_i, rst_ni, cmd.commit, !m_axis_tvalid || m_axis_tready)
  `TPGF_ASSERT_IMP(a_rec_code, clk_i, rst_ni, m_axis_tvalid, rec_ok)

endmodule

/* sv/tpgf_rem.sv */
// Bit-serial remainder unit for the read error count.
module tpgf_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tpgf_pkg::ErrW-1:0]  dividend_i,
  input  logic [tpgf_pkg::ErrW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [tpgf_pkg::ErrW-1:0]  rem_o
);

  logic [tpgf_pkg::RemCntW-1:0] cnt_q, cnt_d;
  logic [tpgf_pkg::ErrW:0]      rem_q, rem_d;
  logic [tpgf_pkg::ErrW-1:0]    dvd_q, dvd_d;
  logic [tpgf_pkg::ErrW:0]      trial;

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    dvd_d = dvd_q;
    trial = {rem_q[tpgf_pkg::ErrW-1:0], dvd_q[tpgf_pkg::ErrW-1]};
    if (start_i) begin
      cnt_d = tpgf_pkg::RemCntW'(tpgf_pkg::ErrW);
      rem_d = '0;
      dvd_d = dividend_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      dvd_d = {dvd_q[tpgf_pkg::ErrW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
      end else begin
        rem_d = trial;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign done_o = (cnt_q == '0) && !start_i;
  assign rem_o  = rem_q[tpgf_pkg::ErrW-1:0];

endmodule

/* sv/tpgf_ctrl.sv */
// Controller sequencing one poll request through the datapath.
module tpgf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  tpgf_pkg::sts_t sts_i,
  output tpgf_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_CHECK,
    ST_DIV,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  always_comb begin
    out_free        = !out_valid_q || out_ready_i;
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o           = '0;
    cmd_o.load      = in_valid_i && (state_q == ST_IDLE);
    cmd_o.calc      = (state_q == ST_CALC);
    cmd_o.div_start = (state_q == ST_CHECK) && sts_i.need_err;
    cmd_o.commit    = (state_q == ST_COMMIT) && out_free;

    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CALC;
      end
      ST_CALC:  state_d = ST_CHECK;
      ST_CHECK: state_d = sts_i.need_err ? ST_DIV : ST_COMMIT;
      ST_DIV: begin
        if (sts_i.rem_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/tpgf_dp.sv */
// Datapath: configuration, poll state, rate and ghost checks, result register.
module tpgf_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tpgf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tpgf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [tpgf_pkg::InW-1:0]      in_data_i,
  input  tpgf_pkg::cmd_t                cmd_i,
  output tpgf_pkg::sts_t                sts_o,
  output logic [tpgf_pkg::OutW-1:0]     out_data_o
);

  // Configuration registers.
  logic                      wa_en_q, idle_lvl_q;
  logic [7:0]                poll_iv_q, g_short_q, g_long_q, g_upd_q;
  logic [15:0]               holdoff_q;
  logic [tpgf_pkg::ErrW-1:0] epr_q;

  // Poll state.
  logic [tpgf_pkg::TimeW-1:0] last_poll_q, last_poll_d;
  logic [tpgf_pkg::TimeW-1:0] t_start_q, t_start_d;
  logic                       touching_q, touching_d;
  logic [tpgf_pkg::UpdW-1:0]  upd_q, upd_d, upd_inc;
  logic [tpgf_pkg::ErrW-1:0]  err_q, err_d, err_inc;
  logic [1:0]                 pend_q, pend_d;

  tpgf_pkg::in_t              in_q;
  tpgf_pkg::out_t             res, out_q;
  logic [tpgf_pkg::TimeW-1:0] d_q, du_q;

  logic [1:0]                 pend_eff, pend_err;
  logic                       polled, too_soon, gated, read_path, status_path, cnt;
  logic                       err_status, err_point, need_err, err_disable, err_mod;
  logic                       t_begin, t_end, neg, is_short, odd, inval;
  logic [tpgf_pkg::ErrW-1:0]  rem;
  logic                       rem_done;

  tpgf_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (err_inc),
    .divisor_i  (epr_q),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_en_q    <= 1'b0;
      idle_lvl_q <= 1'b1;
      poll_iv_q  <= 8'd10;
      holdoff_q  <= 16'd5000;
      g_short_q  <= 8'd15;
      g_long_q   <= 8'd35;
      g_upd_q    <= 8'd4;
      epr_q      <= 6'd8;
    end else if (cfg_we_i) begin
      unique case (tpgf_pkg::cfg_idx_e'(cfg_idx_i))
        tpgf_pkg::CFG_WORKAROUND:    wa_en_q    <= cfg_data_i[0];
        tpgf_pkg::CFG_IDLE_LEVEL:    idle_lvl_q <= cfg_data_i[0];
        tpgf_pkg::CFG_POLL_INTERVAL: poll_iv_q  <= cfg_data_i[7:0];
        tpgf_pkg::CFG_HOLDOFF:       holdoff_q  <= cfg_data_i;
        tpgf_pkg::CFG_GHOST_SHORT:   g_short_q  <= cfg_data_i[7:0];
        tpgf_pkg::CFG_GHOST_LONG:    g_long_q   <= cfg_data_i[7:0];
        tpgf_pkg::CFG_GHOST_UPDATES: g_upd_q    <= cfg_data_i[7:0];
        tpgf_pkg::CFG_ERRORS_PER:    epr_q      <= cfg_data_i[tpgf_pkg::ErrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // A completed recovery clears the pending request before anything else.
    pend_eff = in_q.recovery_done ? tpgf_pkg::RecNone : pend_q;
    too_soon = d_q[tpgf_pkg::TimeW-1] || (d_q < tpgf_pkg::TimeW'(poll_iv_q));
    gated    = (in_q.line_level != idle_lvl_q) && !wa_en_q;
    polled   = !too_soon && !gated;

    read_path   = polled && (pend_eff == tpgf_pkg::RecNone);
    status_path = read_path && in_q.status_ok && in_q.status_byte[tpgf_pkg::ReadyBit];
    cnt         = (in_q.status_byte[3:0] & tpgf_pkg::CountMask) != 4'd0;
    err_status  = read_path && !in_q.status_ok;
    err_point   = status_path && cnt && !in_q.points_ok;
    need_err    = err_status || err_point;

    err_inc     = (err_q != tpgf_pkg::ErrMax) ? err_q + 1'b1 : err_q;
    err_disable = {2'b00, err_inc} > (8'(epr_q) * tpgf_pkg::DisableFactor);
    err_mod     = (epr_q != '0) && (rem == '0);
    if (err_disable) begin
      pend_err = tpgf_pkg::RecDisable;
    end else if (err_mod) begin
      pend_err = tpgf_pkg::RecDisplay;
    end else begin
      pend_err = pend_eff;
    end
    pend_d = need_err ? pend_err : pend_eff;
    err_d  = need_err ? err_inc : err_q;

    upd_inc  = (upd_q != tpgf_pkg::UpdMax) ? upd_q + 1'b1 : upd_q;
    t_begin  = status_path && cnt && !touching_q;
    t_end    = status_path && !cnt && touching_q;
    neg      = du_q[tpgf_pkg::TimeW-1];
    is_short = neg || (du_q < tpgf_pkg::TimeW'(g_short_q));
    odd      = !neg && (du_q > tpgf_pkg::TimeW'(g_short_q))
               && (du_q < tpgf_pkg::TimeW'(g_long_q))
               && (upd_inc != tpgf_pkg::UpdW'(g_upd_q));
    inval    = t_end && (is_short || odd);

    touching_d = touching_q;
    t_start_d  = t_start_q;
    upd_d      = status_path ? upd_inc : upd_q;
    if (t_begin) begin
      touching_d = 1'b1;
      t_start_d  = in_q.now_ms;
    end else if (t_end) begin
      touching_d = 1'b0;
      t_start_d  = '0;
      upd_d      = '0;
    end

    last_poll_d = last_poll_q;
    if (polled) begin
      // A ghost pushes the next allowed poll out by the holdoff time.
      last_poll_d = inval ? in_q.now_ms + tpgf_pkg::TimeW'(holdoff_q) : in_q.now_ms;
    end

    res                  = '0;
    res.polled           = polled;
    res.point_count      = status_path && cnt;
    res.point_valid      = status_path && cnt && in_q.points_ok;
    res.out_x            = res.point_valid ? in_q.point_x : 16'd0;
    res.out_y            = res.point_valid ? in_q.point_y : 16'd0;
    res.invalidate       = inval;
    res.clear_status     = status_path && (pend_d == tpgf_pkg::RecNone);
    res.bus_restart      = need_err && !err_disable && !err_mod;
    res.recovery_request = pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_poll_q <= '0;
      t_start_q   <= '0;
      touching_q  <= 1'b0;
      upd_q       <= '0;
      err_q       <= '0;
      pend_q      <= tpgf_pkg::RecNone;
    end else if (cmd_i.commit) begin
      last_poll_q <= last_poll_d;
      t_start_q   <= t_start_d;
      touching_q  <= touching_d;
      upd_q       <= upd_d;
      err_q       <= err_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= tpgf_pkg::in_t'(in_data_i);
    end
    if (cmd_i.calc) begin
      d_q  <= in_q.now_ms - last_poll_q;
      du_q <= in_q.now_ms - t_start_q;
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign sts_o.need_err = need_err;
  assign sts_o.rem_done = rem_done;
  assign out_data_o     = out_q;

endmodule
